// ===== rtl/rmd_pkg.sv =====
// Shared constants and codes for the record-marking deframer.
package rmd_pkg;

  // Default width of the fragment length field taken from each header.
  localparam int unsigned LengthBitsDefault = 31;
  localparam int unsigned LengthBitsMax     = 31;

  // Event codes carried in the input tuser.
  localparam logic [1:0] OP_DATA      = 2'd0;
  localparam logic [1:0] OP_EOS       = 2'd1;
  localparam logic [1:0] OP_READ_ERR  = 2'd2;

  // Stream status codes carried in the output tuser.
  localparam logic [1:0] ST_NORMAL    = 2'd0;
  localparam logic [1:0] ST_CLEAN_END = 2'd1;
  localparam logic [1:0] ST_TRUNCATED = 2'd2;
  localparam logic [1:0] ST_READ_ERR  = 2'd3;

  // Transaction id is four bytes.
  localparam int unsigned XidBytes = 4;

  // Output tuser bit positions.
  localparam int unsigned UserByteValid = 0;
  localparam int unsigned UserInHeader  = 1;
  localparam int unsigned UserXidValid  = 2;
  localparam int unsigned UserStatusLo  = 3;

endpackage

// ===== rtl/rpc_record_marking_deframer_unit.sv =====
// Record-marking deframer: splits a byte stream into tagged header and payload items.
//
// Usage:
//   Input channel (s_axis): one item per stream event. tuser holds the event kind
//   (data byte, end of stream, read error); tdata holds the stream byte.
//   Output channel (m_axis): exactly one item per accepted input item. tdata holds
//   the passed-through byte and the captured transaction id, tuser the flags and
//   the stream status, tlast marks the byte that closes a record.
//   Each result is registered and is offered in the cycle after its input item is accepted.
//   Throughput: one item per cycle while the output is not stalled; the header
//   assembly, length counter and id capture each update in the same cycle the item
//   is taken, so the next item can follow at once.
//   Stall: the result register holds while m_axis_tready is low; s_axis_tready
//   drops only while a held result is not being taken, so no item is lost.
//   Reset: rst_ni clears the framing state (expecting a header, first fragment,
//   no open record) and empties the result register. End-of-stream and read-error
//   items report their status and then return the framing state to the same point.
//   An unused event code yields an all-zero result and leaves the state alone.
module rpc_record_marking_deframer_unit #(
  parameter int unsigned LENGTH_BITS = rmd_pkg::LengthBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input channel
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic [1:0]  s_axis_tuser,   // [1:0] operation
  // output channel
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [7:0] out_byte, [39:8] xid
  output logic [4:0]  m_axis_tuser,   // [0] byte_valid, [1] in_header, [2] xid_valid,
                                      // [4:3] stream_status
  output logic        m_axis_tlast    // record_end
);
  import rmd_pkg::*;

  localparam int unsigned CntW = $clog2(XidBytes + 1);

  // Framing state
  logic                   in_payload_q, in_payload_d;
  logic [1:0]             hdr_cnt_q, hdr_cnt_d;
  logic [23:0]            hdr_shift_q, hdr_shift_d;   // first three header bytes
  logic [LENGTH_BITS-1:0] remain_q, remain_d;
  logic                   last_frag_q, last_frag_d;
  logic                   first_frag_q, first_frag_d;
  logic                   rec_open_q, rec_open_d;
  logic [CntW-1:0]        xid_cnt_q, xid_cnt_d;
  logic [31:0]            xid_shift_q, xid_shift_d;

  // Result register
  logic        out_valid_q;
  logic [39:0] out_data_q, out_data_d;
  logic [4:0]  out_user_q, out_user_d;
  logic        out_last_q, out_last_d;

  logic        accept;
  logic [31:0] hdr_word;
  logic [LENGTH_BITS-1:0] frag_len;
  logic [LENGTH_BITS-1:0] remain_dec;
  logic        rec_end;
  logic        hdr;
  logic        xv;
  logic [31:0] xid_seen;
  logic [1:0]  status;

  // Take a new item whenever the result register is empty or being drained.
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign hdr_word   = {hdr_shift_q, s_axis_tdata};
  assign frag_len   = hdr_word[LENGTH_BITS-1:0];
  assign remain_dec = remain_q - {{(LENGTH_BITS-1){1'b0}}, 1'b1};

  always_comb begin
    in_payload_d = in_payload_q;
    hdr_cnt_d    = hdr_cnt_q;
    hdr_shift_d  = hdr_shift_q;
    remain_d     = remain_q;
    last_frag_d  = last_frag_q;
    first_frag_d = first_frag_q;
    rec_open_d   = rec_open_q;
    xid_cnt_d    = xid_cnt_q;
    xid_shift_d  = xid_shift_q;
    rec_end      = 1'b0;
    hdr          = 1'b0;
    xv           = 1'b0;
    xid_seen     = '0;
    status       = ST_NORMAL;
    out_data_d   = '0;
    out_user_d   = '0;
    out_last_d   = 1'b0;

    case (s_axis_tuser)
      OP_DATA: begin
        if (!in_payload_q) begin
          // Assemble the big-endian header; decode it on its fourth byte.
          hdr        = 1'b1;
          rec_open_d = 1'b1;
          if (hdr_cnt_q == 2'd3) begin
            last_frag_d = hdr_word[31];
            remain_d    = frag_len;
            hdr_cnt_d   = 2'd0;
            hdr_shift_d = '0;
            if (frag_len == '0) begin
              // Empty fragment closes right on its header.
              rec_end      = hdr_word[31];
              first_frag_d = hdr_word[31];
              rec_open_d   = !hdr_word[31];
            end else begin
              in_payload_d = 1'b1;
            end
          end else begin
            hdr_cnt_d   = hdr_cnt_q + 2'd1;
            hdr_shift_d = hdr_word[23:0];
          end
        end else begin
          // Capture the id from the first payload bytes of the first fragment.
          if (first_frag_q && (xid_cnt_q < CntW'(XidBytes))) begin
            xid_shift_d = {xid_shift_q[23:0], s_axis_tdata};
            xid_cnt_d   = xid_cnt_q + CntW'(1);
          end
          remain_d = remain_dec;
          if (remain_dec == '0) begin
            in_payload_d = 1'b0;
            rec_end      = last_frag_q;
            first_frag_d = last_frag_q;
            if (last_frag_q) begin
              rec_open_d = 1'b0;
            end
          end
        end
        xv       = (xid_cnt_d >= CntW'(XidBytes));
        xid_seen = xv ? xid_shift_d : '0;
        out_data_d = {xid_seen, s_axis_tdata};
        out_user_d[UserByteValid] = 1'b1;
        out_user_d[UserInHeader]  = hdr;
        out_user_d[UserXidValid]  = xv;
        out_last_d = rec_end;
        // Clear the id capture once the record has closed.
        if (rec_end) begin
          xid_cnt_d   = '0;
          xid_shift_d = '0;
        end
      end
      OP_EOS, OP_READ_ERR: begin
        xv       = (xid_cnt_q >= CntW'(XidBytes));
        xid_seen = xv ? xid_shift_q : '0;
        if (s_axis_tuser == OP_READ_ERR) begin
          status = ST_READ_ERR;
        end else if (rec_open_q) begin
          status = ST_TRUNCATED;
        end else begin
          status = ST_CLEAN_END;
        end
        out_data_d = {xid_seen, 8'h00};
        out_user_d[UserXidValid] = xv;
        out_user_d[UserStatusLo +: 2] = status;
        // Return the framing to its reset point.
        in_payload_d = 1'b0;
        hdr_cnt_d    = '0;
        hdr_shift_d  = '0;
        remain_d     = '0;
        last_frag_d  = 1'b0;
        first_frag_d = 1'b1;
        rec_open_d   = 1'b0;
        xid_cnt_d    = '0;
        xid_shift_d  = '0;
      end
      default: begin
        // Unused code: all-zero result, state held.
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_payload_q <= 1'b0;
      hdr_cnt_q    <= '0;
      hdr_shift_q  <= '0;
      remain_q     <= '0;
      last_frag_q  <= 1'b0;
      first_frag_q <= 1'b1;
      rec_open_q   <= 1'b0;
      xid_cnt_q    <= '0;
      xid_shift_q  <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (accept) begin
        in_payload_q <= in_payload_d;
        hdr_cnt_q    <= hdr_cnt_d;
        hdr_shift_q  <= hdr_shift_d;
        remain_q     <= remain_d;
        last_frag_q  <= last_frag_d;
        first_frag_q <= first_frag_d;
        rec_open_q   <= rec_open_d;
        xid_cnt_q    <= xid_cnt_d;
        xid_shift_q  <= xid_shift_d;
        out_valid_q  <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q  <= 1'b0;
      end
    end
  end

  // Result payload: load on accept, hold otherwise.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= out_data_d;
      out_user_q <= out_user_d;
      out_last_q <= out_last_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;
  assign m_axis_tlast  = out_last_q;

endmodule

// ===== rtl/rmd_checker.sv =====
// Port-level checker for the record-marking deframer, bound to the top level.
module rmd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [7:0]  s_axis_tdata,
  input logic [1:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic [4:0]  m_axis_tuser,
  input logic        m_axis_tlast
);
  import rmd_pkg::*;

  // A stalled result stays offered.
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // A record end is always a normal stream byte.
  a_last_is_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |->
      (m_axis_tuser[UserByteValid] && m_axis_tuser[UserStatusLo +: 2] == ST_NORMAL))
    else $error("record end without a stream byte");

  // Status events carry no byte and no header tag.
  a_status_no_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[UserStatusLo +: 2] != ST_NORMAL) |->
      (!m_axis_tuser[UserByteValid] && !m_axis_tuser[UserInHeader] && !m_axis_tlast))
    else $error("status item tagged as a byte");

  // Without a complete id the id field reads zero.
  a_xid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[UserXidValid]) |-> (m_axis_tdata[39:8] == 32'd0))
    else $error("xid shown before it is complete");

  // A data input item always returns a byte result in the following cycle.
  a_data_echo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_DATA) |=>
      (m_axis_tvalid && m_axis_tuser[UserByteValid] && m_axis_tdata[7:0] == $past(s_axis_tdata)))
    else $error("data byte not passed through");

endmodule

bind rpc_record_marking_deframer_unit rmd_checker u_rmd_checker (.*);
